// File: hdl/urtrb_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the UART receive/transmit ring FIFO block.
// Used by urtrb_ctrl, urtrb_dp and uart_rx_tx_ring_buffers; no dependencies.
package urtrb_pkg;

  typedef enum logic [2:0] {
    KIND_RX_BYTE   = 3'd0,
    KIND_HOST_READ = 3'd1,
    KIND_HOST_PEEK = 3'd2,
    KIND_HOST_WR   = 3'd3,
    KIND_TX_READY  = 3'd4,
    KIND_ESC_QUERY = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_RX_EMPTY = 2'd1,
    STAT_TX_FULL  = 2'd2,
    STAT_DROPPED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // register the incoming item and prefetch both FIFO heads
    logic exec;     // apply the item to the FIFO state and load the result
  } cmd_t;

  localparam logic [7:0] ESC_CODE = 8'd27;

endpackage

// File: hdl/urtrb_ctrl.sv
`timescale 1ns / 1ps
// Controller: sequences one item at a time through capture, execute and result.
// Depends on urtrb_pkg.
module urtrb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output urtrb_pkg::cmd_t   cmd
);

  urtrb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= urtrb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    cmd.capture = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state)
      urtrb_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = urtrb_pkg::ST_EXEC;
        end
      end
      urtrb_pkg::ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = urtrb_pkg::ST_RESP;
      end
      urtrb_pkg::ST_RESP: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_next = urtrb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = urtrb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/urtrb_dp.sv
`timescale 1ns / 1ps
// Datapath: RX and TX byte stores, ring pointers, flags and the result register.
// Depends on urtrb_pkg; driven by urtrb_ctrl commands.
module urtrb_dp #(
  parameter int RX_DEPTH = 64,
  parameter int TX_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  urtrb_pkg::cmd_t   cmd,
  input  logic [2:0]        kind,
  input  logic [7:0]        data_byte,
  input  logic              frame_error,
  output logic [7:0]        read_byte,
  output logic [7:0]        line_byte,
  output logic              line_byte_valid,
  output logic [1:0]        status,
  output logic              escape_seen,
  output logic [5:0]        rx_count,
  output logic              rx_empty,
  output logic              tx_empty,
  output logic              tx_ready_enable
);

  localparam int RXW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
  localparam int TXW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int CW  = (RXW > 6) ? RXW : 6;
  localparam logic [RXW-1:0] RX_LAST = RXW'(RX_DEPTH - 1);
  localparam logic [TXW-1:0] TX_LAST = TXW'(TX_DEPTH - 1);

  logic [7:0] rx_mem [RX_DEPTH];
  logic [7:0] tx_mem [TX_DEPTH];

  logic [RXW-1:0] rx_head, rx_tail, rx_head_next, rx_tail_next, rx_head_inc;
  logic [TXW-1:0] tx_head, tx_tail, tx_head_next, tx_tail_next, tx_head_inc;
  logic           escape_flag, escape_flag_next;
  logic           ready_enable, ready_enable_next;

  // captured item and prefetched head-of-queue bytes
  urtrb_pkg::kind_t kind_q;
  logic [7:0]       data_q;
  logic             ferr_q;
  logic [7:0]       rx_rd;
  logic [7:0]       tx_rd;

  logic             rx_we, tx_we;
  logic [7:0]       read_byte_next, line_byte_next;
  logic             line_valid_next;
  logic [1:0]       status_next;
  logic             esc_out_next;
  logic [CW-1:0]    rx_fill;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= urtrb_pkg::kind_t'(kind);
      data_q <= data_byte;
      ferr_q <= frame_error;
      rx_rd  <= rx_mem[rx_tail];
      tx_rd  <= tx_mem[tx_tail];
    end
  end

  always_ff @(posedge clk) begin
    if (rx_we) begin
      rx_mem[rx_head] <= data_q;
    end
    if (tx_we) begin
      tx_mem[tx_head] <= data_q;
    end
  end

  assign rx_head_inc = (rx_head == RX_LAST) ? '0 : rx_head + 1'b1;
  assign tx_head_inc = (tx_head == TX_LAST) ? '0 : tx_head + 1'b1;

  always_comb begin
    rx_head_next      = rx_head;
    rx_tail_next      = rx_tail;
    tx_head_next      = tx_head;
    tx_tail_next      = tx_tail;
    escape_flag_next  = escape_flag;
    ready_enable_next = ready_enable;
    rx_we             = 1'b0;
    tx_we             = 1'b0;
    read_byte_next    = '0;
    line_byte_next    = '0;
    line_valid_next   = 1'b0;
    status_next       = urtrb_pkg::STAT_OK;
    esc_out_next      = 1'b0;
    if (cmd.exec) begin
      case (kind_q)
        urtrb_pkg::KIND_RX_BYTE: begin
          if (ferr_q) begin
            status_next = urtrb_pkg::STAT_DROPPED;
          end else begin
            // escape is flagged even when the byte is lost to overrun
            if (data_q == urtrb_pkg::ESC_CODE) begin
              escape_flag_next = 1'b1;
            end
            if (rx_head_inc == rx_tail) begin
              status_next = urtrb_pkg::STAT_DROPPED;
            end else begin
              rx_we        = 1'b1;
              rx_head_next = rx_head_inc;
            end
          end
        end
        urtrb_pkg::KIND_HOST_READ: begin
          if (rx_head == rx_tail) begin
            status_next = urtrb_pkg::STAT_RX_EMPTY;
          end else begin
            read_byte_next = rx_rd;
            rx_tail_next   = (rx_tail == RX_LAST) ? '0 : rx_tail + 1'b1;
          end
        end
        urtrb_pkg::KIND_HOST_PEEK: begin
          if (rx_head != rx_tail) begin
            read_byte_next = rx_rd;
          end
        end
        urtrb_pkg::KIND_HOST_WR: begin
          if (tx_head_inc == tx_tail) begin
            status_next = urtrb_pkg::STAT_TX_FULL;
          end else begin
            tx_we             = 1'b1;
            tx_head_next      = tx_head_inc;
            ready_enable_next = 1'b1;
          end
        end
        urtrb_pkg::KIND_TX_READY: begin
          if (tx_head == tx_tail) begin
            ready_enable_next = 1'b0;
          end else begin
            line_byte_next  = tx_rd;
            line_valid_next = 1'b1;
            tx_tail_next    = (tx_tail == TX_LAST) ? '0 : tx_tail + 1'b1;
          end
        end
        urtrb_pkg::KIND_ESC_QUERY: begin
          escape_flag_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
    // a query reports the flag as it was; everything else the updated flag
    esc_out_next = (kind_q == urtrb_pkg::KIND_ESC_QUERY) ? escape_flag : escape_flag_next;
  end

  // ring fill; modulo 2^CW arithmetic covers the wrap when depth is 2^RXW
  assign rx_fill = CW'(rx_head_next) - CW'(rx_tail_next)
                 + ((rx_head_next < rx_tail_next) ? CW'(RX_DEPTH) : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_head      <= '0;
      rx_tail      <= '0;
      tx_head      <= '0;
      tx_tail      <= '0;
      escape_flag  <= 1'b0;
      ready_enable <= 1'b1;
    end else begin
      rx_head      <= rx_head_next;
      rx_tail      <= rx_tail_next;
      tx_head      <= tx_head_next;
      tx_tail      <= tx_tail_next;
      escape_flag  <= escape_flag_next;
      ready_enable <= ready_enable_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      read_byte       <= read_byte_next;
      line_byte       <= line_byte_next;
      line_byte_valid <= line_valid_next;
      status          <= status_next;
      escape_seen     <= esc_out_next;
      rx_count        <= rx_fill[5:0];
      rx_empty        <= (rx_head_next == rx_tail_next);
      tx_empty        <= (tx_head_next == tx_tail_next);
      tx_ready_enable <= ready_enable_next;
    end
  end

endmodule

// File: hdl/uart_rx_tx_ring_buffers.sv
`timescale 1ns / 1ps
// UART RX/TX ring FIFOs: top level joining controller and datapath.
// Each accepted item steps through capture, execute and result; the result is
// registered during execute and held valid until taken, and no new item is
// accepted before then: the controller holds one item, prefetching heads at capture.
// Reset clears pointers and escape flag and sets the TX ready enable; stores
// are not cleared and need no sweep.
module uart_rx_tx_ring_buffers #(
  parameter int RX_DEPTH = 64,
  parameter int TX_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] kind,
  input  logic [7:0] data_byte,
  input  logic       frame_error,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] read_byte,
  output logic [7:0] line_byte,
  output logic       line_byte_valid,
  output logic [1:0] status,
  output logic       escape_seen,
  output logic [5:0] rx_count,
  output logic       rx_empty,
  output logic       tx_empty,
  output logic       tx_ready_enable
);

  urtrb_pkg::cmd_t cmd;

  urtrb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  urtrb_dp #(
    .RX_DEPTH (RX_DEPTH),
    .TX_DEPTH (TX_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .kind            (kind),
    .data_byte       (data_byte),
    .frame_error     (frame_error),
    .read_byte       (read_byte),
    .line_byte       (line_byte),
    .line_byte_valid (line_byte_valid),
    .status          (status),
    .escape_seen     (escape_seen),
    .rx_count        (rx_count),
    .rx_empty        (rx_empty),
    .tx_empty        (tx_empty),
    .tx_ready_enable (tx_ready_enable)
  );

endmodule
